[rtl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the software timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int NOW_W   = 48;
    localparam int DLY_W   = 32;
    localparam int ID_W    = 32;
    localparam int OWN_W   = 16;
    localparam int EVN_W   = 5;
    localparam int DIV_STEPS = 48;
    localparam int DCNT_W  = 6;

    localparam logic [EVN_W-1:0] MAX_EVENTS = 5'd16;
    localparam logic [NOW_W-1:0] NOW_MAX    = {NOW_W{1'b1}};
    localparam logic [ID_W-1:0]  ID_FIRST   = 32'd1;

    localparam logic [1:0] OP_SCHED  = 2'd0;
    localparam logic [1:0] OP_CHECK  = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] KIND_SCHED  = 2'd0;
    localparam logic [1:0] KIND_EVENT  = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [DLY_W-1:0] delay;
        logic [NOW_W-1:0] deadline;
        logic             rec;
        logic [OWN_W-1:0] owner;
    } t_entry;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_SCHED,
        OUT_CANCEL,
        OUT_PEND
    } t_out_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCHED,
        S_CAN_RD,
        S_CAN_CMP,
        S_CAN_REPLY,
        S_SHIFT,
        S_SHIFT_WR,
        S_CHK_RD,
        S_CHK_CMP,
        S_CHK_DIV,
        S_CHK_EMIT,
        S_CHK_END
    } t_state;

    typedef struct packed {
        logic     load;
        logic     rd_en;
        logic     rd_next;
        logic     wr_sched;
        logic     wr_rearm;
        logic     wr_shift;
        logic     idx_inc;
        logic     sidx_init;
        logic     sidx_inc;
        logic     cnt_dec;
        logic     div_start;
        logic     set_found;
        logic     pend_load;
        logic     pend_clr;
        t_out_sel out_sel;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] in_op;
        logic       reject;
        logic       idx_end;
        logic       n_full;
        logic       id_match;
        logic       expired;
        logic       div_busy;
        logic       out_free;
        logic       pend_valid;
        logic       shift_more;
        logic       rec;
    } t_dp_sts;

    function automatic logic [NOW_W-1:0] sat_add(input logic [NOW_W-1:0] a,
                                                 input logic [DLY_W-1:0] b);
        logic [NOW_W:0] s;
        s = {1'b0, a} + {{(NOW_W-DLY_W+1){1'b0}}, b};
        return s[NOW_W] ? NOW_MAX : s[NOW_W-1:0];
    endfunction

endpackage

[rtl/software_timer_table_core.sv]
// ----------------------------------------------------------------------------
// software_timer_table_core
// Ordered table of software timers with schedule, check and cancel.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (i_valid / o_stall) carry an op and its fields. o_stall is
//   high whenever an item is in progress, so one item is worked at a time.
//   Result words (o_valid / i_stall) come from one output register; o_last
//   marks the final word of an item. A check with nothing expired and op 3
//   give no words.
//   Schedule gives a single reply word. Cancel scans the entries in order
//   and compacts the table by moving each later entry down. Check reads
//   each live entry and runs each expired entry through the one-bit-per-cycle
//   48-step divider; a one-shot removal moves every later entry down.
//   Events are staged one behind, so the final one can carry o_last.
//   When the receiver stalls, the block waits with its word held; the final
//   word of an item can still be waiting when the next item is taken in.
//   Reset clears the entry count, the id counter (to 1) and all handshake
//   state; timer memory holds no reset and is only read below the count.
// ----------------------------------------------------------------------------
module software_timer_table_core #(
    parameter int TIMERS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_op,
    input  logic [stt_pkg::NOW_W-1:0]   i_now_ms,
    input  logic [stt_pkg::DLY_W-1:0]   i_delay_ms,
    input  logic                        i_recurring,
    input  logic [stt_pkg::OWN_W-1:0]   i_owner,
    input  logic [stt_pkg::ID_W-1:0]    i_cancel_id,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_kind,
    output logic [stt_pkg::ID_W-1:0]    o_timer_id,
    output logic [stt_pkg::DLY_W-1:0]   o_elapsed_ticks,
    output logic [stt_pkg::OWN_W-1:0]   o_event_owner,
    output logic                        o_found,
    output logic                        o_last
);
    import stt_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    stt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // storage, arithmetic and result word
    stt_dp #(.TIMERS(TIMERS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_op            (i_op),
        .i_now_ms        (i_now_ms),
        .i_delay_ms      (i_delay_ms),
        .i_recurring     (i_recurring),
        .i_owner         (i_owner),
        .i_cancel_id     (i_cancel_id),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_timer_id      (o_timer_id),
        .o_elapsed_ticks (o_elapsed_ticks),
        .o_event_owner   (o_event_owner),
        .o_found         (o_found),
        .o_last          (o_last)
    );

endmodule

[rtl/stt_div.sv]
// ----------------------------------------------------------------------------
// stt_div
// Restoring divider, one quotient bit per cycle, 48-bit by 32-bit.
// ----------------------------------------------------------------------------
module stt_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [stt_pkg::NOW_W-1:0]    i_num,
    input  logic [stt_pkg::DLY_W-1:0]    i_den,
    output logic                         o_busy,
    output logic [stt_pkg::NOW_W-1:0]    o_quot
);
    import stt_pkg::*;

    logic [NOW_W-1:0]  r_q;
    logic [DLY_W-1:0]  r_rem;
    logic [DLY_W-1:0]  r_d;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic [DLY_W:0]    rem_sh;
    logic              ge;

    assign rem_sh = {r_rem, r_q[NOW_W-1]};
    assign ge     = rem_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DCNT_W'(DIV_STEPS);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - DCNT_W'(1);
            if (r_cnt == DCNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_d   <= (i_den == '0) ? DLY_W'(1) : i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NOW_W-2:0], ge};
            r_rem <= ge ? DLY_W'(rem_sh - {1'b0, r_d}) : rem_sh[DLY_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

[rtl/stt_dp.sv]
// ----------------------------------------------------------------------------
// stt_dp
// Datapath: timer memory, indexes, id counter, event staging, result word.
// ----------------------------------------------------------------------------
module stt_dp #(
    parameter int TIMERS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  stt_pkg::t_dp_cmd            i_cmd,
    output stt_pkg::t_dp_sts            o_sts,
    input  logic [1:0]                  i_op,
    input  logic [stt_pkg::NOW_W-1:0]   i_now_ms,
    input  logic [stt_pkg::DLY_W-1:0]   i_delay_ms,
    input  logic                        i_recurring,
    input  logic [stt_pkg::OWN_W-1:0]   i_owner,
    input  logic [stt_pkg::ID_W-1:0]    i_cancel_id,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_kind,
    output logic [stt_pkg::ID_W-1:0]    o_timer_id,
    output logic [stt_pkg::DLY_W-1:0]   o_elapsed_ticks,
    output logic [stt_pkg::OWN_W-1:0]   o_event_owner,
    output logic                        o_found,
    output logic                        o_last
);
    import stt_pkg::*;

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = $clog2(TIMERS + 1);

    t_entry            mem [TIMERS];
    t_entry            r_rd;
    logic [CW-1:0]     r_count, r_idx, r_sidx;
    logic [EVN_W-1:0]  r_n;
    logic [ID_W-1:0]   r_next_id;
    logic [NOW_W-1:0]  r_now;
    logic [DLY_W-1:0]  r_delay;
    logic              r_rec;
    logic [OWN_W-1:0]  r_own;
    logic [ID_W-1:0]   r_cid;
    logic              r_found;
    logic              r_pend_v;
    logic [ID_W-1:0]   r_pend_id;
    logic [DLY_W-1:0]  r_pend_ticks;
    logic [OWN_W-1:0]  r_pend_own;
    logic              r_out_v;

    logic [CW-1:0]     sidx_p1;
    logic [IW-1:0]     rd_addr, wr_addr;
    t_entry            wr_data, rearm;
    logic              wr_en;
    logic              div_busy;
    logic [NOW_W-1:0]  quot;
    logic [DLY_W-1:0]  ticks;
    logic              out_free;

    assign sidx_p1 = r_sidx + CW'(1);
    assign rd_addr = i_cmd.rd_next ? sidx_p1[IW-1:0] : r_idx[IW-1:0];
    assign out_free = !r_out_v || !i_stall;

    always_comb begin
        rearm          = r_rd;
        rearm.deadline = sat_add(r_now, r_rd.delay);
        wr_en   = i_cmd.wr_sched || i_cmd.wr_rearm || i_cmd.wr_shift;
        wr_addr = r_idx[IW-1:0];
        wr_data = rearm;
        priority if (i_cmd.wr_sched) begin
            wr_addr = r_count[IW-1:0];
            wr_data = '{id: r_next_id, delay: r_delay, deadline: sat_add(r_now, r_delay),
                        rec: r_rec, owner: r_own};
        end else if (i_cmd.wr_shift) begin
            wr_addr = r_sidx[IW-1:0];
            wr_data = r_rd;
        end else begin
            wr_addr = r_idx[IW-1:0];
            wr_data = rearm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    stt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_now - r_rd.deadline),
        .i_den   (r_rd.delay),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    // 1 + q, saturated at all ones
    assign ticks = (quot[NOW_W-1:DLY_W] != '0 || quot[DLY_W-1:0] == '1) ?
                   '1 : quot[DLY_W-1:0] + DLY_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now   <= i_now_ms;
            r_delay <= i_delay_ms;
            r_rec   <= i_recurring;
            r_own   <= i_owner;
            r_cid   <= i_cancel_id;
        end
        if (i_cmd.sidx_init) begin
            r_sidx <= r_idx;
        end else if (i_cmd.sidx_inc) begin
            r_sidx <= sidx_p1;
        end
        if (i_cmd.pend_load) begin
            r_pend_id    <= r_rd.id;
            r_pend_own   <= r_rd.owner;
            r_pend_ticks <= ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_n       <= '0;
            r_next_id <= ID_FIRST;
            r_found   <= 1'b0;
            r_pend_v  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_n     <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.idx_inc) r_idx <= r_idx + CW'(1);
                if (i_cmd.set_found) r_found <= 1'b1;
                if (i_cmd.pend_load) r_n <= r_n + EVN_W'(1);
            end
            if (i_cmd.wr_sched) begin
                r_count   <= r_count + CW'(1);
                r_next_id <= (r_next_id == '1) ? ID_FIRST : r_next_id + ID_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.pend_load) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.pend_clr) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.out_sel != OUT_NONE) begin
            r_out_v <= 1'b1;
        end else if (!i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.out_sel)
            OUT_SCHED: begin
                o_kind          <= KIND_SCHED;
                o_timer_id      <= o_sts.reject ? '0 : r_next_id;
                o_elapsed_ticks <= '0;
                o_event_owner   <= '0;
                o_found         <= !o_sts.reject;
                o_last          <= 1'b1;
            end
            OUT_CANCEL: begin
                o_kind          <= KIND_CANCEL;
                o_timer_id      <= r_cid;
                o_elapsed_ticks <= '0;
                o_event_owner   <= '0;
                o_found         <= r_found;
                o_last          <= 1'b1;
            end
            OUT_PEND: begin
                o_kind          <= KIND_EVENT;
                o_timer_id      <= r_pend_id;
                o_elapsed_ticks <= r_pend_ticks;
                o_event_owner   <= r_pend_own;
                o_found         <= 1'b1;
                o_last          <= i_cmd.out_last;
            end
            OUT_NONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_out_v;

    always_comb begin
        o_sts            = '0;
        o_sts.in_op      = i_op;
        o_sts.reject     = (r_delay == '0) || (r_count >= CW'(TIMERS));
        o_sts.idx_end    = r_idx >= r_count;
        o_sts.n_full     = r_n >= MAX_EVENTS;
        o_sts.id_match   = r_rd.id == r_cid;
        o_sts.expired    = r_now >= r_rd.deadline;
        o_sts.div_busy   = div_busy;
        o_sts.out_free   = out_free;
        o_sts.pend_valid = r_pend_v;
        o_sts.shift_more = sidx_p1 < r_count;
        o_sts.rec        = r_rd.rec;
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TIMERS)) else $error("entry count above table size");
    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != '0) else $error("id counter reached zero");
    a_events_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= MAX_EVENTS) else $error("too many events in one check");
    a_event_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_EVENT |-> o_found) else $error("event without found");

endmodule

[rtl/stt_ctrl.sv]
// ----------------------------------------------------------------------------
// stt_ctrl
// Controller: sequences schedule, check and cancel over the datapath.
// ----------------------------------------------------------------------------
module stt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  stt_pkg::t_dp_sts  i_sts,
    output stt_pkg::t_dp_cmd  o_cmd
);
    import stt_pkg::*;

    t_state r_state, n_state;
    logic   r_ret_chk, n_ret_chk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret_chk <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret_chk <= n_ret_chk;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ret_chk = r_ret_chk;
        o_cmd     = '0;
        o_cmd.out_sel = OUT_NONE;
        o_stall   = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_sts.in_op)
                        OP_SCHED:  n_state = S_SCHED;
                        OP_CHECK:  n_state = S_CHK_RD;
                        OP_CANCEL: n_state = S_CAN_RD;
                        OP_NONE:   n_state = S_IDLE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SCHED: begin
                if (i_sts.out_free) begin
                    o_cmd.out_sel  = OUT_SCHED;
                    o_cmd.wr_sched = !i_sts.reject;
                    n_state = S_IDLE;
                end
            end
            S_CAN_RD: begin
                if (i_sts.idx_end) begin
                    n_state = S_CAN_REPLY;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_CAN_CMP;
                end
            end
            S_CAN_CMP: begin
                if (i_sts.id_match) begin
                    o_cmd.set_found = 1'b1;
                    o_cmd.sidx_init = 1'b1;
                    n_ret_chk = 1'b0;
                    n_state = S_SHIFT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_CAN_RD;
                end
            end
            S_CAN_REPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.out_sel = OUT_CANCEL;
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_more) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state = S_SHIFT_WR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state = r_ret_chk ? S_CHK_RD : S_CAN_REPLY;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.sidx_inc = 1'b1;
                n_state = S_SHIFT;
            end
            S_CHK_RD: begin
                if (i_sts.idx_end || i_sts.n_full) begin
                    n_state = S_CHK_END;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_CHK_CMP;
                end
            end
            S_CHK_CMP: begin
                if (i_sts.expired) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_CHK_DIV;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_CHK_RD;
                end
            end
            S_CHK_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_CHK_EMIT;
                end
            end
            S_CHK_EMIT: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    if (i_sts.pend_valid) begin
                        o_cmd.out_sel = OUT_PEND;
                    end
                    o_cmd.pend_load = 1'b1;
                    if (i_sts.rec) begin
                        o_cmd.wr_rearm = 1'b1;
                        o_cmd.idx_inc  = 1'b1;
                        n_state = S_CHK_RD;
                    end else begin
                        o_cmd.sidx_init = 1'b1;
                        n_ret_chk = 1'b1;
                        n_state = S_SHIFT;
                    end
                end
            end
            S_CHK_END: begin
                if (!i_sts.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.out_sel  = OUT_PEND;
                    o_cmd.out_last = 1'b1;
                    o_cmd.pend_clr = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("load outside idle");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.wr_sched, o_cmd.wr_rearm, o_cmd.wr_shift}) <= 1)
        else $error("two memory writes at once");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> r_state == S_CHK_DIV) else $error("divide not awaited");

endmodule

[tb/sv/tb_software_timer_table_core.sv]
// ----------------------------------------------------------------------------
// tb_software_timer_table_core
// Self-checking bench for the software timer table core.
// ----------------------------------------------------------------------------
// A local mirror of the timer list predicts every result word. Directed tests
// cover rejects, cancel hit and miss, tick and deadline saturation, a full
// table and the ignored op. A long random phase follows. Both sides idle at
// random, and the receiver also holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_software_timer_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int TIMERS = 16;

    typedef struct {
        logic [1:0]       kind;
        logic [ID_W-1:0]  id;
        logic [DLY_W-1:0] ticks;
        logic [OWN_W-1:0] own;
        logic             found;
        logic             last;
    } t_timer_word;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [1:0]       i_op;
    logic [NOW_W-1:0] i_now_ms;
    logic [DLY_W-1:0] i_delay_ms;
    logic             i_recurring;
    logic [OWN_W-1:0] i_owner;
    logic [ID_W-1:0]  i_cancel_id;
    logic             o_valid;
    logic             i_stall;
    logic [1:0]       o_kind;
    logic [ID_W-1:0]  o_timer_id;
    logic [DLY_W-1:0] o_elapsed_ticks;
    logic [OWN_W-1:0] o_event_owner;
    logic             o_found;
    logic             o_last;

    software_timer_table_core #(.TIMERS(TIMERS)) u_top (.*);

    // mirror of the timer list
    logic [ID_W-1:0]  tm_id [TIMERS];
    logic [DLY_W-1:0] tm_dly [TIMERS];
    logic [NOW_W-1:0] tm_dl [TIMERS];
    logic             tm_rec [TIMERS];
    logic [OWN_W-1:0] tm_own [TIMERS];
    int               tm_count;
    logic [ID_W-1:0]  tm_next_id;

    t_timer_word      expected_words[$];
    logic [NOW_W-1:0] clock_ms;
    bit               calm;        // no random idling on either side
    bit               hold_req;    // ask receiver for a long hold-off
    int               hold_left;
    int               errors, n_items, n_words, n_events;

    // ------------------------------------------------------------------
    // clock, limit
    // ------------------------------------------------------------------
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [NOW_W-1:0] deadline_of(logic [NOW_W-1:0] t,
                                                     logic [DLY_W-1:0] d);
        logic [NOW_W:0] s;
        s = {1'b0, t} + {17'd0, d};
        return s[NOW_W] ? NOW_MAX : s[NOW_W-1:0];
    endfunction

    function automatic void drop_entry(int pos);
        for (int j = pos; j + 1 < tm_count; j++) begin
            tm_id[j]  = tm_id[j+1];
            tm_dly[j] = tm_dly[j+1];
            tm_dl[j]  = tm_dl[j+1];
            tm_rec[j] = tm_rec[j+1];
            tm_own[j] = tm_own[j+1];
        end
        tm_count--;
    endfunction

    function automatic void push_word(logic [1:0] k, logic [ID_W-1:0] id,
                                      logic [DLY_W-1:0] t, logic [OWN_W-1:0] o,
                                      logic f, logic l);
        t_timer_word w;
        w.kind = k; w.id = id; w.ticks = t; w.own = o; w.found = f; w.last = l;
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic void predict_timer_item(logic [1:0] op, logic [NOW_W-1:0] t,
                                               logic [DLY_W-1:0] d, logic rec,
                                               logic [OWN_W-1:0] own,
                                               logic [ID_W-1:0] cid);
        int          n, i;
        logic [63:0] q;
        bit          hit;
        n_items++;
        case (op)
            OP_SCHED: begin
                if (d == '0 || tm_count >= TIMERS) begin
                    push_word(KIND_SCHED, '0, '0, '0, 1'b0, 1'b1);
                end else begin
                    tm_id[tm_count]  = tm_next_id;
                    tm_dly[tm_count] = d;
                    tm_dl[tm_count]  = deadline_of(t, d);
                    tm_rec[tm_count] = rec;
                    tm_own[tm_count] = own;
                    tm_count++;
                    push_word(KIND_SCHED, tm_next_id, '0, '0, 1'b1, 1'b1);
                    tm_next_id++;
                    if (tm_next_id == '0) tm_next_id = ID_FIRST;
                end
            end
            OP_CHECK: begin
                n = 0;
                i = 0;
                while (i < tm_count && n < int'(MAX_EVENTS)) begin
                    if (t >= tm_dl[i]) begin
                        q = 64'(t - tm_dl[i]) / 64'(tm_dly[i]);
                        push_word(KIND_EVENT, tm_id[i],
                                  q >= 64'hFFFF_FFFF ? 32'hFFFF_FFFF : 32'(q + 1),
                                  tm_own[i], 1'b1, 1'b0);
                        n++;
                        n_events++;
                        if (tm_rec[i]) begin
                            tm_dl[i] = deadline_of(t, tm_dly[i]);
                            i++;
                        end else begin
                            drop_entry(i);
                        end
                    end else begin
                        i++;
                    end
                end
                if (n > 0) begin
                    expected_words[expected_words.size() - 1].last = 1'b1;
                end
            end
            OP_CANCEL: begin
                hit = 0;
                for (i = 0; i < tm_count && !hit; i++) begin
                    if (tm_id[i] == cid) begin
                        drop_entry(i);
                        hit = 1;
                    end
                end
                push_word(KIND_CANCEL, cid, '0, '0, hit, 1'b1);
            end
            default: ;  // ignored
        endcase
    endfunction

    // ------------------------------------------------------------------
    // input side: one word per call, valid kept high between back to back words
    // ------------------------------------------------------------------
    task automatic send_word(logic [1:0] op, logic [DLY_W-1:0] d = 32'd0,
                             logic rec = 1'b0, logic [OWN_W-1:0] own = '0,
                             logic [ID_W-1:0] cid = '0);
        if (!calm && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_now_ms    <= clock_ms;
        i_delay_ms  <= d;
        i_recurring <= rec;
        i_owner     <= own;
        i_cancel_id <= cid;
        do @(posedge i_clk); while (o_stall);
        predict_timer_item(op, clock_ms, d, rec, own, cid);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (1500) @(posedge i_clk);  // a check with no words may still run
    endtask

    task automatic cancel_all();
        logic [ID_W-1:0] ids[$];
        for (int i = 0; i < tm_count; i++) ids.insert(ids.size(), tm_id[i]);
        foreach (ids[k]) send_word(OP_CANCEL, .cid(ids[k]));
    endtask

    // ------------------------------------------------------------------
    // output side: stall driver and checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 8);
        end
    end

    always @(posedge i_clk) begin
        t_timer_word w;
        if (i_rst_n && o_valid && !i_stall) begin
            n_words++;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word kind=%0d id=%0h", $time, o_kind,
                         o_timer_id);
                errors++;
            end else begin
                w = expected_words.pop_front();
                if (o_kind !== w.kind || o_timer_id !== w.id ||
                    o_elapsed_ticks !== w.ticks || o_event_owner !== w.own ||
                    o_found !== w.found || o_last !== w.last) begin
                    $display("%0t: mismatch exp kind=%0d id=%0h ticks=%0h own=%0h f=%0b l=%0b",
                             $time, w.kind, w.id, w.ticks, w.own, w.found, w.last);
                    $display("%0t:          act kind=%0d id=%0h ticks=%0h own=%0h f=%0b l=%0b",
                             $time, o_kind, o_timer_id, o_elapsed_ticks,
                             o_event_owner, o_found, o_last);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_basic_ops();
        send_word(OP_SCHED, 32'd0, 1'b1, 16'h1234);          // zero delay reject
        send_word(OP_SCHED, 32'd1, 1'b1, 16'hFFFF);
        send_word(OP_SCHED, 32'hFFFF_FFFF, 1'b0, 16'h0000);
        send_word(OP_SCHED, 32'd10, 1'b0, 16'hA5A5);
        send_word(OP_CANCEL, .cid(32'h0));                   // miss
        send_word(OP_CANCEL, .cid(32'hFFFF_FFFF));           // miss
        send_word(OP_CHECK);                                 // nothing expired
        send_word(OP_NONE, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        clock_ms += 25;
        send_word(OP_CHECK);                                 // periodic and one-shot
        send_word(OP_CANCEL, .cid(tm_id[0]));                // hit
        clock_ms += 3;
        send_word(OP_CHECK);
    endtask

    task automatic test_tick_saturation();
        send_word(OP_SCHED, 32'd1, 1'b1, 16'h0F0F);
        clock_ms += 48'h2_0000_0000;                         // ticks past 32 bits
        send_word(OP_CHECK);
        cancel_all();
    endtask

    task automatic test_full_table();
        for (int k = 0; k < TIMERS; k++)
            send_word(OP_SCHED, 32'($urandom_range(1, 40)), k[0], 16'($urandom));
        send_word(OP_SCHED, 32'd5, 1'b0, 16'h7777);          // table full reject
        clock_ms += 100;
        send_word(OP_CHECK);                                 // all sixteen expire
        cancel_all();
    endtask

    task automatic test_random(int count);
        logic [1:0]       op;
        logic [DLY_W-1:0] d;
        logic [ID_W-1:0]  cid;
        int               r;
        for (int k = 0; k < count; k++) begin
            calm = (k >= count / 3 && k < count / 2);
            r = $urandom_range(99);
            if (r < 40)      op = OP_SCHED;
            else if (r < 72) op = OP_CHECK;
            else if (r < 95) op = OP_CANCEL;
            else             op = OP_NONE;
            r = $urandom_range(99);
            if (r < 5)       d = '0;
            else if (r < 15) d = $urandom;
            else             d = $urandom_range(1, 300);
            r = $urandom_range(99);
            if (tm_count > 0 && r < 75) cid = tm_id[$urandom_range(tm_count - 1)];
            else if (r < 90)            cid = $urandom;
            else                        cid = tm_next_id;
            r = $urandom_range(99);
            if (r < 2)       clock_ms += {16'd0, 32'($urandom)};
            else if (r < 10) clock_ms += $urandom_range(0, 1 << 20);
            else             clock_ms += $urandom_range(0, 120);
            send_word(op, d, 1'($urandom), 16'($urandom), cid);
        end
        calm = 0;
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        for (int k = 0; k < 12; k++)
            send_word(OP_SCHED, 32'($urandom_range(1, 50)), 1'b1, 16'($urandom));
        clock_ms += 60;
        send_word(OP_CHECK);
    endtask

    task automatic test_deadline_saturation();
        cancel_all();
        clock_ms = NOW_MAX - 48'd5;
        send_word(OP_SCHED, 32'hFFFF_FFFF, 1'b1, 16'h8001);  // deadline clips
        send_word(OP_SCHED, 32'd3, 1'b0, 16'h0002);
        clock_ms = NOW_MAX;
        send_word(OP_CHECK);
        send_word(OP_CHECK);                                 // re-arm at the max
    endtask

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0; i_op = OP_SCHED;
        i_now_ms = '0; i_delay_ms = '0; i_recurring = 1'b0; i_owner = '0;
        i_cancel_id = '0;
        tm_count = 0; tm_next_id = ID_FIRST; clock_ms = 48'd1000;
        calm = 0; hold_req = 0; hold_left = 0;
        errors = 0; n_items = 0; n_words = 0; n_events = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_tick_saturation();
        test_full_table();
        test_random(290);
        wait_drained();
        test_backpressure();
        test_deadline_saturation();
        wait_drained();

        $display("Covered %0d items and %0d result words, %0d of them expiry events,",
                 n_items, n_words, n_events);
        $display("with rejects, cancels, full table, saturation and long stalls.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
